// ===== sv/i2cmra_pkg.sv =====
// Shared types and constants for the I2C master register access core.
package i2cmra_pkg;

  localparam logic [1:0] CMD_TICK        = 2'd0;
  localparam logic [1:0] CMD_SINGLE_WR   = 2'd1;
  localparam logic [1:0] CMD_SINGLE_RD   = 2'd2;
  localparam logic [1:0] CMD_MULTI_RD    = 2'd3;

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_BUS_BUSY     = 2'd1;
  localparam logic [1:0] ST_START_FAIL   = 2'd2;
  localparam logic [1:0] ST_ADDR_NACK    = 2'd3;

  localparam logic [15:0] RECOVERY_RESET = 16'd1250;

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive;
    logic       busy_res;
    logic       byte_valid;
    logic [7:0] read_byte;
    logic       done_res;
    logic [1:0] status;
    logic       last_byte;
  } result_t;

endpackage

// ===== sv/i2cmra_engine.sv =====
// Bus sequencer: holds transaction state and computes the result of one beat.
module i2cmra_engine (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  logic [1:0]               cmd,
  input  logic [7:0]               slave_address_byte,
  input  logic [7:0]               register_address,
  input  logic [7:0]               write_value,
  input  logic [7:0]               read_length,
  input  logic                     sda_level,
  input  logic [15:0]              write_recovery_ticks,
  output i2cmra_pkg::result_t      result
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_START1, PH_ADDR, PH_ACK1, PH_REG, PH_ACK2, PH_DATA, PH_ACK3,
    PH_START2, PH_RADDR, PH_ACK4, PH_RECV, PH_RACK, PH_STOP, PH_STOPFAIL, PH_WAIT
  } phase_t;

  phase_t      phase, phase_next;
  logic [1:0]  quarter_step, quarter_step_next;
  logic [2:0]  bit_index, bit_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [1:0]  operation, operation_next;
  logic [7:0]  saved_address, saved_address_next;
  logic [7:0]  saved_register, saved_register_next;
  logic [7:0]  saved_data, saved_data_next;
  logic [15:0] recovery_count, recovery_count_next;
  logic        scl_reg, scl_reg_next;
  logic        sda_reg, sda_reg_next;

  function automatic phase_t follow(phase_t p, logic [1:0] op, logic [7:0] left);
    phase_t r;
    r = PH_IDLE;
    unique case (p)
      PH_START1: r = PH_ADDR;
      PH_ADDR:   r = PH_ACK1;
      PH_ACK1:   r = PH_REG;
      PH_REG:    r = PH_ACK2;
      PH_ACK2:   r = (op == i2cmra_pkg::CMD_SINGLE_WR) ? PH_DATA : PH_START2;
      PH_DATA:   r = PH_ACK3;
      PH_ACK3:   r = PH_STOP;
      PH_START2: r = PH_RADDR;
      PH_RADDR:  r = PH_ACK4;
      PH_ACK4,
      PH_RACK:   r = (left != 8'd0) ? PH_RECV : PH_STOP;
      PH_RECV:   r = PH_RACK;
      default:   r = PH_IDLE;
    endcase
    return r;
  endfunction

  always_comb begin
    logic       do_enter;
    phase_t     target;
    logic       fin;
    logic [1:0] st;
    logic       chk;
    logic [7:0] shifted;
    logic [15:0] rc_dec;
    logic       valid;
    logic [7:0] rb;
    logic       last;

    phase_next          = phase;
    quarter_step_next   = quarter_step;
    bit_index_next      = bit_index;
    shift_byte_next     = shift_byte;
    bytes_left_next     = bytes_left;
    operation_next      = operation;
    saved_address_next  = saved_address;
    saved_register_next = saved_register;
    saved_data_next     = saved_data;
    recovery_count_next = recovery_count;
    scl_reg_next        = scl_reg;
    sda_reg_next        = sda_reg;
    do_enter = 1'b0;
    target   = PH_IDLE;
    fin      = 1'b0;
    st       = i2cmra_pkg::ST_OK;
    chk      = 1'b0;
    shifted  = {shift_byte[6:0], sda_level};
    rc_dec   = (recovery_count != 16'd0) ? recovery_count - 16'd1 : 16'd0;
    valid    = 1'b0;
    rb       = 8'd0;
    last     = 1'b0;

    if (cmd != i2cmra_pkg::CMD_TICK) begin
      if (phase == PH_IDLE) begin
        operation_next      = cmd;
        saved_address_next  = slave_address_byte;
        saved_register_next = register_address;
        saved_data_next     = write_value;
        bytes_left_next     = (cmd == i2cmra_pkg::CMD_SINGLE_RD) ? 8'd1 : read_length;
        do_enter = 1'b1;
        target   = PH_START1;
      end
    end else begin
      unique case (phase)
        PH_START1, PH_START2: begin
          chk = (phase == PH_START1) && (operation != i2cmra_pkg::CMD_MULTI_RD);
          if (quarter_step == 2'd0) begin
            scl_reg_next = 1'b1;
            sda_reg_next = 1'b1;
            if (!sda_level) begin
              if (chk) begin
                fin = 1'b1;
                st  = i2cmra_pkg::ST_BUS_BUSY;
              end else begin
                do_enter = 1'b1;
                target   = follow(phase, operation, bytes_left);
              end
            end else begin
              quarter_step_next = 2'd1;
            end
          end else begin
            sda_reg_next = 1'b0;
            if (quarter_step == 2'd1 && sda_level) begin
              if (chk) begin
                fin = 1'b1;
                st  = i2cmra_pkg::ST_START_FAIL;
              end else begin
                do_enter = 1'b1;
                target   = follow(phase, operation, bytes_left);
              end
            end else if (quarter_step >= 2'd2) begin
              do_enter = 1'b1;
              target   = follow(phase, operation, bytes_left);
            end else begin
              quarter_step_next = quarter_step + 2'd1;
            end
          end
        end
        PH_ADDR, PH_REG, PH_DATA, PH_RADDR: begin
          if (quarter_step == 2'd0) begin
            scl_reg_next      = 1'b0;
            quarter_step_next = 2'd1;
          end else if (quarter_step == 2'd1) begin
            sda_reg_next      = shift_byte[7];
            shift_byte_next   = {shift_byte[6:0], 1'b0};
            quarter_step_next = 2'd2;
          end else begin
            scl_reg_next = 1'b1;
            if (bit_index == 3'd7) begin
              do_enter = 1'b1;
              target   = follow(phase, operation, bytes_left);
            end else begin
              bit_index_next    = bit_index + 3'd1;
              quarter_step_next = 2'd0;
            end
          end
        end
        PH_ACK1, PH_ACK2, PH_ACK3, PH_ACK4: begin
          if (quarter_step == 2'd0) begin
            scl_reg_next      = 1'b0;
            quarter_step_next = 2'd1;
          end else if (quarter_step == 2'd1) begin
            sda_reg_next      = 1'b1;
            quarter_step_next = 2'd2;
          end else begin
            scl_reg_next = 1'b1;
            do_enter     = 1'b1;
            if (phase == PH_ACK1 && operation != i2cmra_pkg::CMD_MULTI_RD && sda_level) begin
              target = PH_STOPFAIL;
            end else begin
              target = follow(phase, operation, bytes_left);
            end
          end
        end
        PH_RECV: begin
          if (quarter_step == 2'd0) begin
            scl_reg_next      = 1'b0;
            sda_reg_next      = 1'b1;
            quarter_step_next = 2'd1;
          end else begin
            scl_reg_next    = 1'b1;
            shift_byte_next = shifted;
            if (bit_index == 3'd7) begin
              valid = 1'b1;
              rb    = shifted;
              last  = (bytes_left <= 8'd1);
              if (bytes_left != 8'd0) begin
                bytes_left_next = bytes_left - 8'd1;
              end
              do_enter = 1'b1;
              target   = PH_RACK;
            end else begin
              bit_index_next    = bit_index + 3'd1;
              quarter_step_next = 2'd0;
            end
          end
        end
        PH_RACK: begin
          unique case (quarter_step)
            2'd0: scl_reg_next = 1'b0;
            2'd1: sda_reg_next = (bytes_left == 8'd0);
            2'd2: scl_reg_next = 1'b1;
            default: begin
              scl_reg_next = 1'b0;
              do_enter     = 1'b1;
              target       = follow(phase, operation, bytes_left);
            end
          endcase
          if (quarter_step != 2'd3) begin
            quarter_step_next = quarter_step + 2'd1;
          end
        end
        PH_STOP, PH_STOPFAIL: begin
          unique case (quarter_step)
            2'd0: scl_reg_next = 1'b0;
            2'd1: sda_reg_next = 1'b0;
            2'd2: scl_reg_next = 1'b1;
            default: begin
              sda_reg_next = 1'b1;
              if (phase == PH_STOPFAIL) begin
                fin = 1'b1;
                st  = i2cmra_pkg::ST_ADDR_NACK;
              end else if (operation == i2cmra_pkg::CMD_SINGLE_WR &&
                           write_recovery_ticks != 16'd0) begin
                recovery_count_next = write_recovery_ticks;
                do_enter = 1'b1;
                target   = PH_WAIT;
              end else begin
                fin = 1'b1;
              end
            end
          endcase
          if (quarter_step != 2'd3) begin
            quarter_step_next = quarter_step + 2'd1;
          end
        end
        PH_WAIT: begin
          recovery_count_next = rc_dec;
          if (rc_dec == 16'd0) begin
            fin = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    if (fin) begin
      do_enter = 1'b1;
      target   = PH_IDLE;
    end

    if (do_enter) begin
      phase_next        = target;
      quarter_step_next = 2'd0;
      bit_index_next    = 3'd0;
      unique case (target)
        PH_ADDR:  shift_byte_next = saved_address_next;
        PH_REG:   shift_byte_next = saved_register_next;
        PH_DATA:  shift_byte_next = saved_data_next;
        PH_RADDR: shift_byte_next = saved_address_next + 8'd1;
        PH_RECV:  shift_byte_next = 8'd0;
        default: begin
        end
      endcase
    end

    result.scl_level  = scl_reg_next;
    result.sda_drive  = sda_reg_next;
    result.busy_res   = (phase_next != PH_IDLE);
    result.byte_valid = valid;
    result.read_byte  = rb;
    result.done_res   = fin;
    result.status     = fin ? st : i2cmra_pkg::ST_OK;
    result.last_byte  = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      quarter_step   <= 2'd0;
      bit_index      <= 3'd0;
      shift_byte     <= 8'd0;
      bytes_left     <= 8'd0;
      operation      <= 2'd0;
      saved_address  <= 8'd0;
      saved_register <= 8'd0;
      saved_data     <= 8'd0;
      recovery_count <= 16'd0;
      scl_reg        <= 1'b1;
      sda_reg        <= 1'b1;
    end else if (step) begin
      phase          <= phase_next;
      quarter_step   <= quarter_step_next;
      bit_index      <= bit_index_next;
      shift_byte     <= shift_byte_next;
      bytes_left     <= bytes_left_next;
      operation      <= operation_next;
      saved_address  <= saved_address_next;
      saved_register <= saved_register_next;
      saved_data     <= saved_data_next;
      recovery_count <= recovery_count_next;
      scl_reg        <= scl_reg_next;
      sda_reg        <= sda_reg_next;
    end
  end

endmodule

// ===== sv/i2c_master_register_access_core.sv =====
// Top level of the I2C master register access core: stream ports, config, output register.
// Each input beat is either a command (tuser nonzero) or one quarter-bit tick of the
// bus carrying the sampled SDA level, and every beat produces exactly one output beat
// with the SCL/SDA drive levels, busy and done flags, status and any received byte.
// The core takes one beat per clock: the sequencer state and the step logic sit between
// the state registers and a single output register, and a new beat is accepted whenever
// that register is empty or being drained in the same cycle. write_recovery_ticks may be
// written at any time the core is idle and takes effect for the next single write.
module i2c_master_register_access_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,   // write_recovery_ticks
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // slave_address_byte, register_address, write_value,
                                     // read_length, sda_level, zero fill
  input  logic [1:0]  s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // scl_level, sda_drive, busy_res, byte_valid,
                                     // read_byte, done_res, status, zero fill
  output logic        m_axis_tlast   // last_byte
);

  logic [15:0]          write_recovery_ticks;
  logic                 step;
  i2cmra_pkg::result_t  result;
  i2cmra_pkg::result_t  out_reg;
  logic                 out_valid;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;

  i2cmra_engine u_engine (
    .clk                  (clk),
    .rst                  (rst),
    .step                 (step),
    .cmd                  (s_axis_tuser),
    .slave_address_byte   (s_axis_tdata[7:0]),
    .register_address     (s_axis_tdata[15:8]),
    .write_value          (s_axis_tdata[23:16]),
    .read_length          (s_axis_tdata[31:24]),
    .sda_level            (s_axis_tdata[32]),
    .write_recovery_ticks (write_recovery_ticks),
    .result               (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      write_recovery_ticks <= i2cmra_pkg::RECOVERY_RESET;
    end else if (cfg_wr_en) begin
      write_recovery_ticks <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_reg <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_reg.last_byte;
  assign m_axis_tdata  = {1'b0, out_reg.status, out_reg.done_res, out_reg.read_byte,
                          out_reg.byte_valid, out_reg.busy_res, out_reg.sda_drive,
                          out_reg.scl_level};

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for the I2C master register access core: tick-level bus prediction and beat checks.
module tb_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_BEATS    = 60;

  typedef enum logic [3:0] {
    BUS_IDLE, BUS_START1, BUS_ADDR, BUS_ACK1, BUS_REG, BUS_ACK2, BUS_DATA, BUS_ACK3,
    BUS_START2, BUS_RADDR, BUS_ACK4, BUS_RECV, BUS_RACK, BUS_STOP, BUS_STOPFAIL, BUS_WAIT
  } bus_phase_t;

  typedef enum int {SDA_CLEAN, SDA_NOISE, SDA_BUSY, SDA_NOSTART, SDA_NACK} sda_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic [39:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = i2cmra_pkg::CMD_TICK;
  logic        m_axis_tready = 1'b1;
  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [15:0] m_axis_tdata;
  wire         m_axis_tlast;

  bit          idling = 1'b1;
  int          beats_sent = 0;
  int          mismatches = 0;
  int          idle_cycles = 0;
  i2cmra_pkg::result_t bus_reports_q[$];

  // bus model state
  bus_phase_t  bus_phase;
  logic [1:0]  quarter;
  logic [2:0]  bit_pos;
  logic [7:0]  shifter;
  logic [7:0]  bytes_to_read;
  logic [1:0]  active_cmd;
  logic [7:0]  dev_addr;
  logic [7:0]  reg_addr;
  logic [7:0]  wr_byte;
  logic [15:0] wait_left;
  logic        scl_out;
  logic        sda_out;
  logic [15:0] recovery_ticks;

  always #10 clk = ~clk;

  i2c_master_register_access_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  function automatic void reset_bus_model();
    recovery_ticks = i2cmra_pkg::RECOVERY_RESET;
    bus_phase = BUS_IDLE;
    quarter = '0;
    bit_pos = '0;
    shifter = '0;
    bytes_to_read = '0;
    active_cmd = i2cmra_pkg::CMD_TICK;
    dev_addr = '0;
    reg_addr = '0;
    wr_byte = '0;
    wait_left = '0;
    scl_out = 1'b1;
    sda_out = 1'b1;
  endfunction

  function automatic void enter_phase(bus_phase_t p);
    bus_phase = p;
    quarter = '0;
    bit_pos = '0;
    case (p)
      BUS_ADDR:  shifter = dev_addr;
      BUS_REG:   shifter = reg_addr;
      BUS_DATA:  shifter = wr_byte;
      BUS_RADDR: shifter = dev_addr + 8'd1;
      BUS_RECV:  shifter = 8'd0;
      default: ;
    endcase
  endfunction

  function automatic void next_phase();
    case (bus_phase)
      BUS_START1: enter_phase(BUS_ADDR);
      BUS_ADDR:   enter_phase(BUS_ACK1);
      BUS_ACK1:   enter_phase(BUS_REG);
      BUS_REG:    enter_phase(BUS_ACK2);
      BUS_ACK2: begin
        if (active_cmd == i2cmra_pkg::CMD_SINGLE_WR) enter_phase(BUS_DATA);
        else enter_phase(BUS_START2);
      end
      BUS_DATA:   enter_phase(BUS_ACK3);
      BUS_ACK3:   enter_phase(BUS_STOP);
      BUS_START2: enter_phase(BUS_RADDR);
      BUS_RADDR:  enter_phase(BUS_ACK4);
      BUS_ACK4, BUS_RACK: begin
        if (bytes_to_read != 0) enter_phase(BUS_RECV);
        else enter_phase(BUS_STOP);
      end
      BUS_RECV:   enter_phase(BUS_RACK);
      default:    enter_phase(BUS_IDLE);
    endcase
  endfunction

  function automatic i2cmra_pkg::result_t i2c_quarter_step(logic [1:0] cmd, logic [39:0] data);
    i2cmra_pkg::result_t r;
    logic       sin;
    logic       chk;
    logic       fin;
    logic [1:0] q;
    logic [1:0] st;
    r = '0;
    sin = data[32];
    q = quarter;
    fin = 1'b0;
    st = i2cmra_pkg::ST_OK;
    if (cmd != i2cmra_pkg::CMD_TICK) begin
      if (bus_phase == BUS_IDLE) begin
        active_cmd = cmd;
        dev_addr = data[7:0];
        reg_addr = data[15:8];
        wr_byte = data[23:16];
        bytes_to_read = (cmd == i2cmra_pkg::CMD_SINGLE_RD) ? 8'd1 : data[31:24];
        enter_phase(BUS_START1);
      end
    end else begin
      case (bus_phase)
        BUS_START1, BUS_START2: begin
          chk = (bus_phase == BUS_START1) && (active_cmd != i2cmra_pkg::CMD_MULTI_RD);
          if (q == 0) begin
            scl_out = 1'b1;
            sda_out = 1'b1;
            if (!sin) begin
              if (chk) begin
                fin = 1'b1;
                st = i2cmra_pkg::ST_BUS_BUSY;
              end else next_phase();
            end else quarter = q + 2'd1;
          end else begin
            sda_out = 1'b0;
            if (q == 1 && sin) begin
              if (chk) begin
                fin = 1'b1;
                st = i2cmra_pkg::ST_START_FAIL;
              end else next_phase();
            end else if (q >= 2) next_phase();
            else quarter = q + 2'd1;
          end
        end
        BUS_ADDR, BUS_REG, BUS_DATA, BUS_RADDR: begin
          if (q == 0) begin
            scl_out = 1'b0;
            quarter = 2'd1;
          end else if (q == 1) begin
            sda_out = shifter[7];
            shifter = shifter << 1;
            quarter = 2'd2;
          end else begin
            scl_out = 1'b1;
            if (bit_pos == 3'd7) next_phase();
            else begin
              bit_pos = bit_pos + 3'd1;
              quarter = 2'd0;
            end
          end
        end
        BUS_ACK1, BUS_ACK2, BUS_ACK3, BUS_ACK4: begin
          if (q == 0) begin
            scl_out = 1'b0;
            quarter = 2'd1;
          end else if (q == 1) begin
            sda_out = 1'b1;
            quarter = 2'd2;
          end else begin
            scl_out = 1'b1;
            if (bus_phase == BUS_ACK1 && active_cmd != i2cmra_pkg::CMD_MULTI_RD && sin)
              enter_phase(BUS_STOPFAIL);
            else next_phase();
          end
        end
        BUS_RECV: begin
          if (q == 0) begin
            scl_out = 1'b0;
            sda_out = 1'b1;
            quarter = 2'd1;
          end else begin
            scl_out = 1'b1;
            shifter = {shifter[6:0], sin};
            if (bit_pos == 3'd7) begin
              r.byte_valid = 1'b1;
              r.read_byte = shifter;
              r.last_byte = (bytes_to_read <= 8'd1);
              if (bytes_to_read != 0) bytes_to_read = bytes_to_read - 8'd1;
              next_phase();
            end else begin
              bit_pos = bit_pos + 3'd1;
              quarter = 2'd0;
            end
          end
        end
        BUS_RACK: begin
          case (q)
            2'd0: scl_out = 1'b0;
            2'd1: sda_out = (bytes_to_read == 0);
            2'd2: scl_out = 1'b1;
            default: ;
          endcase
          if (q == 3) begin
            scl_out = 1'b0;
            next_phase();
          end else quarter = q + 2'd1;
        end
        BUS_STOP, BUS_STOPFAIL: begin
          case (q)
            2'd0: scl_out = 1'b0;
            2'd1: sda_out = 1'b0;
            2'd2: scl_out = 1'b1;
            default: ;
          endcase
          if (q == 3) begin
            sda_out = 1'b1;
            if (bus_phase == BUS_STOPFAIL) begin
              fin = 1'b1;
              st = i2cmra_pkg::ST_ADDR_NACK;
            end else if (active_cmd == i2cmra_pkg::CMD_SINGLE_WR && recovery_ticks != 0) begin
              wait_left = recovery_ticks;
              enter_phase(BUS_WAIT);
            end else fin = 1'b1;
          end else quarter = q + 2'd1;
        end
        BUS_WAIT: begin
          if (wait_left != 0) wait_left = wait_left - 16'd1;
          if (wait_left == 0) fin = 1'b1;
        end
        default: bus_phase = BUS_IDLE;
      endcase
    end
    if (fin) enter_phase(BUS_IDLE);
    r.scl_level = scl_out;
    r.sda_drive = sda_out;
    r.busy_res = (bus_phase != BUS_IDLE);
    r.done_res = fin;
    r.status = fin ? st : i2cmra_pkg::ST_OK;
    return r;
  endfunction

  // SDA level a slave on the bus would give, bent by the chosen fault
  function automatic logic pick_sda(sda_mode_t mode);
    logic is_start;
    logic is_ack;
    is_start = (bus_phase == BUS_START1) || (bus_phase == BUS_START2);
    is_ack = (bus_phase == BUS_ACK1) || (bus_phase == BUS_ACK2) ||
             (bus_phase == BUS_ACK3) || (bus_phase == BUS_ACK4);
    if (mode == SDA_NOISE && $urandom_range(0, 4) == 0) return 1'($urandom_range(0, 1));
    if (mode == SDA_BUSY && is_start && quarter == 0) return 1'b0;
    if (mode == SDA_NOSTART && is_start && quarter == 1) return 1'b1;
    if (mode == SDA_NACK && is_ack) return 1'b1;
    if (is_start) return (quarter == 0);
    if (is_ack) return 1'b0;
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [39:0] tick_data(logic sda);
    return {7'd0, sda, 32'($urandom())};
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_beat(input logic [1:0] cmd, input logic [39:0] data);
    if (idling && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= data;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    bus_reports_q.push_back(i2c_quarter_step(cmd, data));
    beats_sent++;
  endtask

  task automatic finish_transaction(input sda_mode_t mode);
    while (bus_phase != BUS_IDLE) begin
      if (mode == SDA_NOISE && $urandom_range(0, 40) == 0)
        send_beat(2'($urandom_range(1, 3)), tick_data(1'($urandom_range(0, 1))));
      else
        send_beat(i2cmra_pkg::CMD_TICK, tick_data(pick_sda(mode)));
    end
  endtask

  task automatic run_transaction(input logic [1:0] cmd, input logic [7:0] addr,
                                 input logic [7:0] regb, input logic [7:0] val,
                                 input logic [7:0] len, input sda_mode_t mode);
    send_beat(cmd, {7'd0, 1'($urandom_range(0, 1)), len, val, regb, addr});
    finish_transaction(mode);
  endtask

  // hold the sender until every result is back, then write the register
  task automatic set_recovery(input logic [15:0] value);
    s_axis_tvalid <= 1'b0;
    while (bus_reports_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    recovery_ticks = value;
  endtask

  task automatic test_idle_ticks();
    send_beat(i2cmra_pkg::CMD_TICK, 40'h00_0000_0000);
    send_beat(i2cmra_pkg::CMD_TICK, 40'h01_0000_0000);
    send_beat(i2cmra_pkg::CMD_TICK, 40'hFF_FFFF_FFFF);
  endtask

  task automatic test_single_write();
    set_recovery(16'd0);
    run_transaction(i2cmra_pkg::CMD_SINGLE_WR, 8'hFF, 8'h00, 8'hA5, 8'h00, SDA_CLEAN);
    set_recovery(16'd1);
    run_transaction(i2cmra_pkg::CMD_SINGLE_WR, 8'h00, 8'hFF, 8'h5A, 8'hFF, SDA_CLEAN);
  endtask

  task automatic test_single_read();
    run_transaction(i2cmra_pkg::CMD_SINGLE_RD, 8'hFF, 8'h80, 8'h00, 8'h00, SDA_CLEAN);
  endtask

  task automatic test_multi_read();
    run_transaction(i2cmra_pkg::CMD_MULTI_RD, 8'hA0, 8'h10, 8'h00, 8'd0, SDA_CLEAN);
    run_transaction(i2cmra_pkg::CMD_MULTI_RD, 8'hFF, 8'h12, 8'h00, 8'd2, SDA_CLEAN);
  endtask

  task automatic test_start_faults();
    run_transaction(i2cmra_pkg::CMD_SINGLE_WR, 8'h20, 8'h01, 8'h11, 8'd0, SDA_BUSY);
    run_transaction(i2cmra_pkg::CMD_SINGLE_RD, 8'h20, 8'h02, 8'h00, 8'd0, SDA_BUSY);
    run_transaction(i2cmra_pkg::CMD_SINGLE_WR, 8'h20, 8'h03, 8'h22, 8'd0, SDA_NOSTART);
    run_transaction(i2cmra_pkg::CMD_SINGLE_RD, 8'h20, 8'h04, 8'h00, 8'd0, SDA_NOSTART);
    run_transaction(i2cmra_pkg::CMD_MULTI_RD, 8'h20, 8'h05, 8'h00, 8'd0, SDA_BUSY);
  endtask

  task automatic test_addr_nack();
    run_transaction(i2cmra_pkg::CMD_SINGLE_WR, 8'h50, 8'h07, 8'h33, 8'd0, SDA_NACK);
    run_transaction(i2cmra_pkg::CMD_SINGLE_RD, 8'h50, 8'h08, 8'h00, 8'd0, SDA_NACK);
  endtask

  task automatic test_busy_commands();
    set_recovery(16'd20);
    send_beat(i2cmra_pkg::CMD_SINGLE_RD, {7'd0, 1'b1, 8'd4, 8'h77, 8'h0A, 8'h90});
    send_beat(i2cmra_pkg::CMD_TICK, tick_data(pick_sda(SDA_CLEAN)));
    send_beat(i2cmra_pkg::CMD_SINGLE_WR, {7'd0, 1'b0, 8'd9, 8'h66, 8'h0B, 8'h92});
    send_beat(i2cmra_pkg::CMD_MULTI_RD, {7'd0, 1'b1, 8'd7, 8'h55, 8'h0C, 8'h94});
    finish_transaction(SDA_CLEAN);
    send_beat(i2cmra_pkg::CMD_SINGLE_WR, {7'd0, 1'b1, 8'd0, 8'hC6, 8'h0D, 8'h96});
    while (bus_phase != BUS_WAIT)
      send_beat(i2cmra_pkg::CMD_TICK, tick_data(pick_sda(SDA_CLEAN)));
    send_beat(i2cmra_pkg::CMD_SINGLE_RD, {7'd0, 1'b0, 8'd2, 8'h12, 8'h0E, 8'h98});
    finish_transaction(SDA_CLEAN);
  endtask

  task automatic test_random_traffic(input int beats);
    int        target;
    int        pick;
    sda_mode_t mode;
    target = beats_sent + beats;
    while (beats_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 3))
          send_beat(i2cmra_pkg::CMD_TICK, tick_data(1'($urandom_range(0, 1))));
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 6) mode = SDA_CLEAN;
        else if (pick < 8) mode = SDA_NOISE;
        else if (pick == 8) mode = $urandom_range(0, 1) ? SDA_BUSY : SDA_NOSTART;
        else mode = SDA_NACK;
        run_transaction(2'($urandom_range(1, 3)), 8'($urandom()), 8'($urandom()),
                        8'($urandom()), 8'($urandom_range(0, 4)), mode);
      end
    end
  endtask

  task automatic test_drain_pause();
    set_recovery(16'($urandom_range(0, 6)));
    test_random_traffic(PHASE_BEATS);
  endtask

  task automatic test_full_rate();
    idling = 1'b0;
    set_recovery(16'd2);
    test_random_traffic(PHASE_BEATS);
  endtask

  // output side stalls
  initial begin
    forever begin
      @(posedge clk);
      if (idling && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    i2cmra_pkg::result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (bus_reports_q.size() == 0) begin
        $error("result beat with nothing expected");
        mismatches++;
      end else begin
        want = bus_reports_q.pop_front();
        check_field("scl_level", 8'(want.scl_level), 8'(m_axis_tdata[0]));
        check_field("sda_drive", 8'(want.sda_drive), 8'(m_axis_tdata[1]));
        check_field("busy_res", 8'(want.busy_res), 8'(m_axis_tdata[2]));
        check_field("byte_valid", 8'(want.byte_valid), 8'(m_axis_tdata[3]));
        check_field("read_byte", want.read_byte, m_axis_tdata[11:4]);
        check_field("done_res", 8'(want.done_res), 8'(m_axis_tdata[12]));
        check_field("status", 8'(want.status), 8'(m_axis_tdata[14:13]));
        check_field("last_byte", 8'(want.last_byte), 8'(m_axis_tlast));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    reset_bus_model();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_idle_ticks();
    test_single_write();
    test_single_read();
    test_multi_read();
    test_start_faults();
    test_addr_nack();
    test_busy_commands();
    test_drain_pause();
    test_full_rate();
    s_axis_tvalid <= 1'b0;
    while (bus_reports_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && bus_reports_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
